// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i; ASSERT_CLK is disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Check a property on every rising edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check a property on every rising edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== hw/rtl/hrmd_pkg.sv =====
// ----------------------------------------------------------------------------
// hrmd_pkg
// Constants shared by the digest reduction to decimal block.
// ----------------------------------------------------------------------------
package hrmd_pkg;

  // Datapath widths
  localparam int unsigned DigestBits  = 128;
  localparam int unsigned SumBits     = DigestBits + 1;
  localparam int unsigned HalfBits    = 64;
  localparam int unsigned IndexBits   = 32;
  localparam int unsigned RemBits     = 64;
  localparam int unsigned StepBits    = 8;
  localparam int unsigned CharBits    = 6;
  localparam int unsigned PassLenBits = 5;

  // Most decimal digits of a 64-bit remainder
  localparam int unsigned MaxDigits   = 20;

  // Configuration port
  localparam int unsigned CfgIdxBits  = 2;
  localparam int unsigned CfgDataBits = 64;
  localparam logic [CfgIdxBits-1:0] CfgSetSize    = 2'd0;
  localparam logic [CfgIdxBits-1:0] CfgPassLength = 2'd1;

  // Reset values
  localparam logic [RemBits-1:0]     SetSizeReset = 64'd10000;
  localparam logic [PassLenBits-1:0] PassLenReset = 5'd4;

  // Last step index of the two iterative phases (steps count down to zero)
  localparam logic [StepBits-1:0] ReduceLast  = 8'(DigestBits);
  localparam logic [StepBits-1:0] ConvertLast = 8'(RemBits - 1);

  // ASCII '0'
  localparam logic [CharBits-1:0] CharZero = 6'd48;

endpackage

// ===== hw/rtl/hash_reduce_mod_decimal.sv =====
// ----------------------------------------------------------------------------
// hash_reduce_mod_decimal
// Adds a chain index to a 128-bit digest, reduces the sum modulo the configured
// modulus (zero: low 64 bits kept) and streams it out as ASCII decimal, MSD first.
// ----------------------------------------------------------------------------
// A request is accepted, reduced by the restoring remainder loop (skipped when the
// modulus is zero), converted to BCD by shift-add-3 and its digits counted before
// the first digit shows. No new request is taken until the last digit has gone out.
// Reset clears control state and loads a modulus of 10000 and pass length 4;
// the digit store is not reset.

`include "assert_macros.svh"

module hash_reduce_mod_decimal (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration writes
  input  logic                                 cfg_we_i,
  input  logic [hrmd_pkg::CfgIdxBits-1:0]      cfg_idx_i,
  input  logic [hrmd_pkg::CfgDataBits-1:0]     cfg_data_i,
  // input requests
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [hrmd_pkg::HalfBits-1:0]        digest_high_i,
  input  logic [hrmd_pkg::HalfBits-1:0]        digest_low_i,
  input  logic [hrmd_pkg::IndexBits-1:0]       chain_index_i,
  // output requests
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [hrmd_pkg::CharBits-1:0]        digit_char_o,
  output logic                                 last_digit_o
);

  localparam int unsigned NumDigits = hrmd_pkg::MaxDigits;
  localparam int unsigned PosW = (NumDigits > 1) ? $clog2(NumDigits) : 1;
  localparam int unsigned CntW = $clog2(NumDigits + 1);
  localparam int unsigned SumW = hrmd_pkg::SumBits;
  localparam int unsigned RemW = hrmd_pkg::RemBits;

  typedef enum logic [2:0] {
    StIdle,
    StReduce,
    StConvert,
    StCount,
    StEmit
  } state_e;

  state_e                           state_q, state_d;
  logic [RemW-1:0]                  modulus_q;
  logic [hrmd_pkg::PassLenBits-1:0] pass_len_q;
  logic [SumW-1:0]                  div_q, div_d;
  logic [RemW-1:0]                  rem_q, rem_d;
  logic [hrmd_pkg::StepBits-1:0]    step_q, step_d;
  logic [PosW-1:0]                  pos_q, pos_d;
  logic                             out_valid_q, out_valid_d;
  logic [hrmd_pkg::CharBits-1:0]    char_q, char_d;
  logic                             last_q, last_d;
  logic [3:0]                       store_q [NumDigits];
  logic [3:0]                       store_d [NumDigits];

  logic [SumW-1:0]  sum;
  logic [RemW-1:0]  r2, rem_sub;
  logic             do_sub;
  logic [3:0]       adj     [NumDigits];
  logic [3:0]       shifted [NumDigits];
  logic [CntW-1:0]  n_sig, want, total;
  logic [PosW-1:0]  total_m1;

  // Add the chain index to the digest
  assign sum = {1'b0, digest_high_i, digest_low_i} + {{(SumW - hrmd_pkg::IndexBits){1'b0}},
                                                      chain_index_i};

  // Restoring remainder step: shift one dividend bit in, subtract when it fits
  assign r2      = {rem_q[RemW-2:0], div_q[SumW-1]};
  assign do_sub  = rem_q[RemW-1] | (r2 >= modulus_q);
  assign rem_sub = r2 - modulus_q;

  // Shift-add-3 step: correct each BCD digit, then shift the remainder MSB in
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      adj[i] = (store_q[i] >= 4'd5) ? store_q[i] + 4'd3 : store_q[i];
    end
    for (int i = 0; i < NumDigits; i++) begin
      if (i == 0) begin
        shifted[i] = {adj[i][2:0], rem_q[RemW-1]};
      end else begin
        shifted[i] = {adj[i][2:0], adj[i-1][3]};
      end
    end
  end

  // Count significant digits and apply the padding length
  always_comb begin
    n_sig = CntW'(1);
    for (int i = 1; i < NumDigits; i++) begin
      if (store_q[i] != 4'd0) begin
        n_sig = CntW'(i + 1);
      end
    end
    if (pass_len_q == '0) begin
      want = CntW'(1);
    end else if (pass_len_q > hrmd_pkg::PassLenBits'(NumDigits)) begin
      want = CntW'(NumDigits);
    end else begin
      want = CntW'(pass_len_q);
    end
    total    = (n_sig > want) ? n_sig : want;
    total_m1 = PosW'(total - CntW'(1));
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    div_d       = div_q;
    rem_d       = rem_q;
    step_d      = step_q;
    pos_d       = pos_q;
    out_valid_d = out_valid_q;
    char_d      = char_q;
    last_d      = last_q;
    store_d     = store_q;

    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          div_d = sum;
          for (int i = 0; i < NumDigits; i++) begin
            store_d[i] = 4'd0;
          end
          if (modulus_q == '0) begin
            rem_d   = sum[RemW-1:0];
            step_d  = hrmd_pkg::ConvertLast;
            state_d = StConvert;
          end else begin
            rem_d   = '0;
            step_d  = hrmd_pkg::ReduceLast;
            state_d = StReduce;
          end
        end
      end
      StReduce: begin
        rem_d = do_sub ? rem_sub : r2;
        div_d = {div_q[SumW-2:0], 1'b0};
        if (step_q == '0) begin
          step_d  = hrmd_pkg::ConvertLast;
          state_d = StConvert;
        end else begin
          step_d = step_q - hrmd_pkg::StepBits'(1);
        end
      end
      StConvert: begin
        store_d = shifted;
        rem_d   = {rem_q[RemW-2:0], 1'b0};
        if (step_q == '0) begin
          state_d = StCount;
        end else begin
          step_d = step_q - hrmd_pkg::StepBits'(1);
        end
      end
      StCount: begin
        pos_d       = total_m1;
        out_valid_d = 1'b1;
        char_d      = hrmd_pkg::CharZero | {2'b00, store_q[total_m1]};
        last_d      = (total_m1 == '0);
        state_d     = StEmit;
      end
      StEmit: begin
        if (!out_stall_i) begin
          if (pos_q == '0) begin
            out_valid_d = 1'b0;
            last_d      = 1'b0;
            state_d     = StIdle;
          end else begin
            pos_d  = pos_q - PosW'(1);
            char_d = hrmd_pkg::CharZero | {2'b00, store_q[pos_q - PosW'(1)]};
            last_d = (pos_q == PosW'(1));
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Hold state, configuration and the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      modulus_q   <= hrmd_pkg::SetSizeReset;
      pass_len_q  <= hrmd_pkg::PassLenReset;
      step_q      <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
      char_q      <= hrmd_pkg::CharZero;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
      char_q      <= char_d;
      last_q      <= last_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          hrmd_pkg::CfgSetSize:    modulus_q  <= cfg_data_i;
          hrmd_pkg::CfgPassLength: pass_len_q <= cfg_data_i[hrmd_pkg::PassLenBits-1:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath registers, no reset
  always_ff @(posedge clk_i) begin
    div_q   <= div_d;
    rem_q   <= rem_d;
    store_q <= store_d;
  end

  assign in_stall_o   = (state_q != StIdle);
  assign out_valid_o  = out_valid_q;
  assign digit_char_o = char_q;
  assign last_digit_o = last_q;

  // Assertions
  `ASSERT_ALWAYS(a_no_accept_while_emit, out_valid_o |-> in_stall_o, "input taken while emitting")
  `ASSERT_CLK(a_busy_after_accept, (in_valid_i && !in_stall_o) |=> in_stall_o, "idle after accept")
  `ASSERT_CLK(a_digit, out_valid_o |-> digit_char_o >= 6'd48 && digit_char_o <= 6'd57, "bad digit")
  `ASSERT_CLK(a_last, out_valid_o && last_digit_o && !out_stall_i |=> !out_valid_o, "extra digit")
  `ASSERT_CLK(a_reduce_count, state_q == StReduce |-> step_q <= hrmd_pkg::ReduceLast, "overrun")

endmodule
